@@ design/imr_pkg.sv @@
package imr_pkg;

    localparam logic [1:0] CFG_OUT_OFFSET   = 2'd0;
    localparam logic [1:0] CFG_ACT_MIN      = 2'd1;
    localparam logic [1:0] CFG_ACT_MAX      = 2'd2;
    localparam logic [1:0] CFG_NUM_CHANNELS = 2'd3;

    // partial product chunk of the accumulator magnitude
    localparam int CHUNK_W = 16;
    localparam int MULT_W  = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABS,
        ST_MUL,
        ST_SHIFT,
        ST_SAT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic acc_en;
        logic abs_en;
        logic mul_en;
        logic mul_first;
        logic shift_en;
        logic sat_en;
        logic emit_en;
        logic col;
    } dp_cmd_t;

endpackage

@@ design/imr_ctrl.sv @@
module imr_ctrl #(
    parameter int ACC_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              last_in_row,
    input  logic              out_stall,
    output logic              in_stall,
    output logic              out_valid,
    output imr_pkg::dp_cmd_t  cmd
);
    import imr_pkg::*;

    localparam int NCH   = (ACC_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int CNT_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NCH - 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              col_reg, col_next;
    logic              out_valid_reg, out_valid_next;
    logic              emit_ok;

    assign emit_ok = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        col_next   = col_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && last_in_row)
                begin
                    state_next = ST_ABS;
                    col_next   = 1'b0;
                end
            end
            ST_ABS:
            begin
                state_next = ST_MUL;
                cnt_next   = '0;
            end
            ST_MUL:
            begin
                if (cnt_reg == CNT_LAST)
                    state_next = ST_SHIFT;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_SHIFT:
                state_next = ST_SAT;
            ST_SAT:
            begin
                if (col_reg == 1'b0)
                begin
                    state_next = ST_ABS;
                    col_next   = 1'b1;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_ok)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.col        = col_reg;
        cmd.mul_first  = (cnt_reg == '0);
        in_stall       = (state_reg != ST_IDLE);
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:  cmd.acc_en   = in_valid;
            ST_ABS:   cmd.abs_en   = 1'b1;
            ST_MUL:   cmd.mul_en   = 1'b1;
            ST_SHIFT: cmd.shift_en = 1'b1;
            ST_SAT:   cmd.sat_en   = 1'b1;
            ST_EMIT:
            begin
                cmd.emit_en = emit_ok;
                if (emit_ok)
                    out_valid_next = 1'b1;
            end
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            col_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ design/imr_dp.sv @@
module imr_dp #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  imr_pkg::dp_cmd_t    cmd,
    input  logic signed [7:0]   weight,
    input  logic signed [15:0]  act_col0,
    input  logic signed [15:0]  act_col1,
    input  logic signed [31:0]  bias,
    input  logic [31:0]         scale_mult,
    input  logic [5:0]          scale_shift,
    input  logic                last_in_row,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output logic signed [7:0]   out_col0,
    output logic signed [7:0]   out_col1,
    output logic                last_channel
);
    import imr_pkg::*;

    localparam int NCH    = (ACC_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int MAG_W  = NCH * CHUNK_W;
    localparam int PW     = MAG_W + MULT_W;
    localparam int BIAS_W = (ACC_WIDTH > 32) ? ACC_WIDTH : 32;

    // configuration
    logic signed [7:0]  out_offset_reg, act_min_reg, act_max_reg;
    logic [15:0]        num_channels_reg;

    // row state
    logic signed [ACC_WIDTH-1:0] acc0_reg, acc1_reg, acc0_next, acc1_next;
    logic                        row_start_reg;
    logic [15:0]                 chan_cnt_reg, chan_cnt_next;
    logic                        last_ch_reg, last_ch_next;

    // requant datapath
    logic [31:0]         mult_reg;
    logic [5:0]          shift_amt_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic                neg_reg;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [PW-1:0]       shifted_reg;
    logic signed [7:0]   res0_reg, res1_reg, res_next;
    logic signed [7:0]   out_col0_reg, out_col1_reg;
    logic                last_channel_reg;

    logic signed [23:0]          mac0, mac1;
    logic signed [BIAS_W-1:0]    bias_wide;
    logic signed [ACC_WIDTH-1:0] bias_acc, base0, base1, acc_sel;
    logic [ACC_WIDTH-1:0]        mag_abs;
    logic [CHUNK_W-1:0]          chunk;
    logic [CHUNK_W+MULT_W-1:0]   pp;
    logic                        over;
    logic signed [10:0]          sc, v;
    logic [15:0]                 chan_inc;

    assign mac0      = weight * act_col0;
    assign mac1      = weight * act_col1;
    assign bias_wide = BIAS_W'(bias);
    assign bias_acc  = bias_wide[ACC_WIDTH-1:0];
    assign base0     = row_start_reg ? bias_acc : acc0_reg;
    assign base1     = row_start_reg ? bias_acc : acc1_reg;
    assign acc0_next = base0 + ACC_WIDTH'(mac0);
    assign acc1_next = base1 + ACC_WIDTH'(mac1);

    assign chan_inc      = chan_cnt_reg + 16'd1;
    assign last_ch_next  = (chan_inc == num_channels_reg);
    assign chan_cnt_next = last_ch_next ? 16'd0 : chan_inc;

    assign acc_sel = cmd.col ? acc1_reg : acc0_reg;
    assign mag_abs = acc_sel[ACC_WIDTH-1] ? (ACC_WIDTH'(0) - acc_sel) : acc_sel;

    // magnitude times multiplier, most significant chunk first
    assign chunk     = mag_reg[MAG_W-1 -: CHUNK_W];
    assign pp        = chunk * mult_reg;
    assign prod_next = (cmd.mul_first ? PW'(0) : (prod_reg << CHUNK_W)) + PW'(pp);

    // Saturating to -512..511 gives the same clamped byte as saturating to 32 bits,
    // since offset and bounds are all within a byte.
    assign over = |shifted_reg[PW-1:9];
    always_comb
    begin
        if (neg_reg)
            sc = over ? -11'sd512 : -$signed({2'b00, shifted_reg[8:0]});
        else
            sc = over ? 11'sd511 : $signed({2'b00, shifted_reg[8:0]});
        v = sc + 11'(out_offset_reg);
        if (v < 11'(act_min_reg))
            v = 11'(act_min_reg);
        if (v > 11'(act_max_reg))
            v = 11'(act_max_reg);
        res_next = v[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_offset_reg   <= 8'sd0;
            act_min_reg      <= -8'sd128;
            act_max_reg      <= 8'sd127;
            num_channels_reg <= 16'd1;
            row_start_reg    <= 1'b1;
            chan_cnt_reg     <= 16'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_OUT_OFFSET:   out_offset_reg   <= cfg_data[7:0];
                    CFG_ACT_MIN:      act_min_reg      <= cfg_data[7:0];
                    CFG_ACT_MAX:      act_max_reg      <= cfg_data[7:0];
                    CFG_NUM_CHANNELS: num_channels_reg <= cfg_data;
                    default:          num_channels_reg <= num_channels_reg;
                endcase
            end
            if (cmd.acc_en)
            begin
                row_start_reg <= last_in_row;
                if (last_in_row)
                    chan_cnt_reg <= chan_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_en)
        begin
            acc0_reg      <= acc0_next;
            acc1_reg      <= acc1_next;
            mult_reg      <= scale_mult;
            shift_amt_reg <= scale_shift;
            last_ch_reg   <= last_ch_next;
        end
        if (cmd.abs_en)
        begin
            mag_reg <= MAG_W'(mag_abs);
            neg_reg <= acc_sel[ACC_WIDTH-1];
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
            mag_reg  <= mag_reg << CHUNK_W;
        end
        if (cmd.shift_en)
            shifted_reg <= prod_reg >> shift_amt_reg;
        if (cmd.sat_en)
        begin
            if (cmd.col)
                res1_reg <= res_next;
            else
                res0_reg <= res_next;
        end
        if (cmd.emit_en)
        begin
            out_col0_reg     <= res0_reg;
            out_col1_reg     <= res1_reg;
            last_channel_reg <= last_ch_reg;
        end
    end

    assign out_col0     = out_col0_reg;
    assign out_col1     = out_col1_reg;
    assign last_channel = last_channel_reg;

endmodule

@@ design/int8_int16_matmul_requant.sv @@
// channel  handshake               payload
// in       in_valid / in_stall     weight, act_col0, act_col1, bias, scale_mult,
//                                  scale_shift, last_in_row
// out      out_valid / out_stall   out_col0, out_col1, last_channel
// cfg      cfg_we                  cfg_index, cfg_data
//
// A beat without last_in_row does both MACs in its accept cycle.
// A beat with last_in_row then requantizes both columns, NCH = ceil(ACC_WIDTH/16):
// each column is requantized on a shared 16x32 multiplier,
// one chunk of the accumulator magnitude per cycle.
// in_stall is high while requantizing and while a result waits for the output
// register; a finished result waits in the output register while the next row streams in.
// Reset: config to defaults, row start set, channel count cleared, controller idle, out_valid low.
module int8_int16_matmul_requant #(
    parameter int ACC_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [7:0]  weight,
    input  logic signed [15:0] act_col0,
    input  logic signed [15:0] act_col1,
    input  logic signed [31:0] bias,
    input  logic [31:0]        scale_mult,
    input  logic [5:0]         scale_shift,
    input  logic               last_in_row,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [7:0]  out_col0,
    output logic signed [7:0]  out_col1,
    output logic               last_channel,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import imr_pkg::*;

    dp_cmd_t cmd;

    imr_ctrl #(.ACC_WIDTH(ACC_WIDTH)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_in_row (last_in_row),
        .out_stall   (out_stall),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .cmd         (cmd)
    );

    imr_dp #(.ACC_WIDTH(ACC_WIDTH)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .weight       (weight),
        .act_col0     (act_col0),
        .act_col1     (act_col1),
        .bias         (bias),
        .scale_mult   (scale_mult),
        .scale_shift  (scale_shift),
        .last_in_row  (last_in_row),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_col0     (out_col0),
        .out_col1     (out_col1),
        .last_channel (last_channel)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import imr_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    // covers the requant pass with plenty of margin
    localparam int QUIET_CYCLES = 40;

    typedef struct {
        logic signed [7:0]  weight;
        logic signed [15:0] act0;
        logic signed [15:0] act1;
        logic signed [31:0] bias;
        logic [31:0]        mult;
        logic [5:0]         shift;
        logic               last;
    } row_beat_t;

    typedef struct {
        logic signed [7:0] col0;
        logic signed [7:0] col1;
        logic              last_ch;
    } out_bytes_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [7:0]  weight;
    logic signed [15:0] act_col0;
    logic signed [15:0] act_col1;
    logic signed [31:0] bias;
    logic [31:0]        scale_mult;
    logic [5:0]         scale_shift;
    logic               last_in_row;
    logic               out_valid;
    logic               out_stall;
    logic signed [7:0]  out_col0;
    logic signed [7:0]  out_col1;
    logic               last_channel;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    // shadow of the block's registers and running state
    logic signed [7:0] cfg_ofs = 8'sd0;
    logic signed [7:0] cfg_min = -8'sd128;
    logic signed [7:0] cfg_max = 8'sd127;
    logic [15:0]       cfg_nch = 16'd1;
    logic [31:0]       sum0 = '0;
    logic [31:0]       sum1 = '0;
    logic              row_open = 1'b0;
    logic [15:0]       chan_cnt = '0;

    out_bytes_t  pending_outputs[$];
    out_bytes_t  got_exp;
    int unsigned errors = 0;
    int unsigned beats_sent = 0;
    int unsigned rows_checked = 0;
    int unsigned last_ch_rows = 0;
    int unsigned reg_writes = 0;
    int unsigned in_stall_cycles = 0;
    int unsigned out_hold_cycles = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned hold_request = 0;

    int8_int16_matmul_requant dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .weight       (weight),
        .act_col0     (act_col0),
        .act_col1     (act_col1),
        .bias         (bias),
        .scale_mult   (scale_mult),
        .scale_shift  (scale_shift),
        .last_in_row  (last_in_row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_col0     (out_col0),
        .out_col1     (out_col1),
        .last_channel (last_channel),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d rows outstanding",
                     cycle_count, pending_outputs.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // scaled = trunc(acc * mult / 2^sh), saturated to 32 bits, offset, clamped
    function automatic logic signed [7:0] requantize(logic [31:0] acc, logic [31:0] mult,
                                                     logic [5:0] sh);
        logic [31:0] mag;
        logic [63:0] prod;
        longint      scaled;
        mag = acc[31] ? (~acc + 32'd1) : acc;
        prod = 64'(mag) * 64'(mult);
        prod = prod >> sh;
        if (acc[31])
            scaled = (prod > 64'h8000_0000) ? -longint'(64'h8000_0000) : -longint'(prod);
        else
            scaled = (prod > 64'h7fff_ffff) ? longint'(64'h7fff_ffff) : longint'(prod);
        scaled += longint'(cfg_ofs);
        // max applied after min, so crossed bounds give act_max
        if (scaled < longint'(cfg_min))
            scaled = cfg_min;
        if (scaled > longint'(cfg_max))
            scaled = cfg_max;
        return scaled[7:0];
    endfunction

    task automatic mac_and_requantize(input row_beat_t b);
        int         prod0;
        int         prod1;
        logic [15:0] nxt;
        out_bytes_t r;
        prod0 = int'(b.weight) * int'(b.act0);
        prod1 = int'(b.weight) * int'(b.act1);
        if (!row_open)
        begin
            sum0 = b.bias;
            sum1 = b.bias;
        end
        sum0 = sum0 + 32'(prod0);
        sum1 = sum1 + 32'(prod1);
        if (!b.last)
        begin
            row_open = 1'b1;
            return;
        end
        row_open = 1'b0;
        nxt = chan_cnt + 16'd1;
        r.last_ch = (nxt == cfg_nch);
        chan_cnt = r.last_ch ? 16'd0 : nxt;
        r.col0 = requantize(sum0, b.mult, b.shift);
        r.col1 = requantize(sum1, b.mult, b.shift);
        pending_outputs.push_back(r);
    endtask

    // output side: count stalls, compare every accepted beat against the oldest prediction
    always @(posedge clk)
    begin
        if (in_valid && in_stall)
            in_stall_cycles++;
        if (rst_n && out_valid && out_stall)
            out_hold_cycles++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("output beat with no row pending: %0d %0d last_channel=%0b",
                       out_col0, out_col1, last_channel);
                errors++;
            end
            else
            begin
                got_exp = pending_outputs.pop_front();
                rows_checked++;
                if (got_exp.last_ch)
                    last_ch_rows++;
                if (out_col0 !== got_exp.col0)
                begin
                    $error("out_col0: expected %0d, got %0d", got_exp.col0, out_col0);
                    errors++;
                end
                if (out_col1 !== got_exp.col1)
                begin
                    $error("out_col1: expected %0d, got %0d", got_exp.col1, out_col1);
                    errors++;
                end
                if (last_channel !== got_exp.last_ch)
                begin
                    $error("last_channel: expected %0b, got %0b", got_exp.last_ch,
                           last_channel);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern, changing mode every so often; long hold-offs on request
    initial
    begin
        int unsigned hold_left;
        int unsigned mode;
        int unsigned mode_left;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    task automatic send_beat(input row_beat_t b);
        in_valid    <= 1'b1;
        weight      <= b.weight;
        act_col0    <= b.act0;
        act_col1    <= b.act1;
        bias        <= b.bias;
        scale_mult  <= b.mult;
        scale_shift <= b.shift;
        last_in_row <= b.last;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
        mac_and_requantize(b);
    endtask

    // bursts of random length with random gaps, sometimes back to back
    task automatic pace();
        int unsigned gap;
        if (burst_left != 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // upper byte of cfg_data is don't-care for the 8-bit registers
    task automatic program_regs(input int ofs, input int amin, input int amax,
                                input int unsigned nch);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OUT_OFFSET;
        cfg_data  <= {8'($urandom), 8'(ofs)};
        @(posedge clk);
        cfg_index <= CFG_ACT_MIN;
        cfg_data  <= {8'($urandom), 8'(amin)};
        @(posedge clk);
        cfg_index <= CFG_ACT_MAX;
        cfg_data  <= {8'($urandom), 8'(amax)};
        @(posedge clk);
        cfg_index <= CFG_NUM_CHANNELS;
        cfg_data  <= 16'(nch);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_ofs = 8'(ofs);
        cfg_min = 8'(amin);
        cfg_max = 8'(amax);
        cfg_nch = 16'(nch);
        reg_writes += 4;
    endtask

    function automatic row_beat_t make_beat(input int w, input int a0, input int a1,
                                            input logic [31:0] b, input logic [31:0] m,
                                            input int sh, input bit last);
        row_beat_t r;
        r.weight = 8'(w);
        r.act0   = 16'(a0);
        r.act1   = 16'(a1);
        r.bias   = b;
        r.mult   = m;
        r.shift  = 6'(sh);
        r.last   = last;
        return r;
    endfunction

    function automatic row_beat_t rand_beat(input bit last);
        row_beat_t r;
        case ($urandom_range(0, 9))
            0: r.weight = -8'sd128;
            1: r.weight = 8'sd127;
            default: r.weight = 8'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0: r.act0 = -16'sd32768;
            1: r.act0 = 16'sd32767;
            2, 3, 4: r.act0 = 16'($urandom_range(0, 127) - 64);
            default: r.act0 = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0: r.act1 = -16'sd32768;
            1: r.act1 = 16'sd32767;
            2, 3, 4: r.act1 = 16'($urandom_range(0, 127) - 64);
            default: r.act1 = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0: r.bias = 32'h8000_0000;
            1: r.bias = 32'h7fff_ffff;
            2, 3: r.bias = $urandom;
            default: r.bias = 32'($urandom_range(0, 8191) - 4096);
        endcase
        case ($urandom_range(0, 9))
            0: r.mult = 32'd0;
            1: r.mult = 32'hffff_ffff;
            2: r.mult = 32'd1;
            default: r.mult = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0: r.shift = 6'd0;
            1: r.shift = 6'd63;
            2, 3: r.shift = 6'($urandom);
            default: r.shift = 6'($urandom_range(28, 56));
        endcase
        r.last = last;
        return r;
    endfunction

    // whole rows of random length; most short, a few long
    task automatic run_rows(input int unsigned n_beats, input bit paced);
        int unsigned done;
        int unsigned len;
        int unsigned sel;
        int unsigned i;
        done = 0;
        while (done < n_beats)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 12)
                len = $urandom_range(1, 4);
            else if (sel < 18)
                len = $urandom_range(5, 10);
            else
                len = $urandom_range(11, 30);
            for (i = 0; i < len; i++)
            begin
                send_beat(rand_beat(i == len - 1));
                if (paced)
                    pace();
            end
            done += len;
        end
    endtask

    task automatic test_directed_corners();
        program_regs(0, -128, 127, 1);
        send_beat(make_beat(1, 1, -1, 0, 32'h8000_0000, 31, 1));
        pace();
        send_beat(make_beat(-128, -32768, 32767, 0, 1, 0, 1));
        pace();
        send_beat(make_beat(0, 0, 0, 32'h7fff_ffff, 32'hffff_ffff, 63, 1));
        send_beat(make_beat(0, 0, 0, 32'h8000_0000, 1, 0, 1));
        send_beat(make_beat(127, 32767, -32768, 123, 0, 5, 1));
        // truncation toward zero on a negative sum
        send_beat(make_beat(1, -3, 3, 0, 1, 1, 1));
        send_beat(make_beat(1, -32768, 32767, 32'h8000_0000, 32'hffff_ffff, 0, 1));
        pace();
        // multi-beat row wrapping the sums; bias and scale ignored mid-row
        send_beat(make_beat(-128, -32768, 32767, 32'h7fff_fff0, $urandom, $urandom, 0));
        send_beat(make_beat(-128, -32768, 32767, $urandom, $urandom, $urandom, 0));
        send_beat(make_beat(127, 32767, -32768, $urandom, 32'h4000_0000, 60, 1));
        send_beat(make_beat(3, 1000, -2000, 32'hffff_f000, $urandom, $urandom, 0));
        send_beat(make_beat(-5, -700, 900, $urandom, $urandom, $urandom, 0));
        send_beat(make_beat(7, 12345, -54321, $urandom, $urandom, $urandom, 0));
        send_beat(make_beat(-1, -1, 1, $urandom, 32'h6000_0000, 40, 1));
    endtask

    task automatic test_crossed_clamp();
        int unsigned i;
        program_regs(127, 50, -50, 3);
        send_beat(make_beat(0, 0, 0, 32'h8000_0000, 1, 0, 1));
        for (i = 0; i < 4; i++)
            send_beat(rand_beat(1'b1));
        send_beat(rand_beat(1'b0));
        send_beat(rand_beat(1'b1));
        program_regs(-128, 127, -128, 2);
        for (i = 0; i < 3; i++)
            send_beat(rand_beat(1'b1));
    endtask

    task automatic test_random_configs();
        int lo;
        int unsigned k;
        program_regs(-128, -128, 127, 1);
        run_rows(250, 1'b1);
        program_regs(127, -128, 127, 16'hffff);
        run_rows(220, 1'b1);
        // zero channels behaves as 65536
        program_regs(0, -128, 127, 0);
        run_rows(180, 1'b1);
        for (k = 0; k < 3; k++)
        begin
            lo = $urandom_range(0, 200) - 128;
            program_regs($urandom_range(0, 255) - 128, lo, lo + $urandom_range(0, 127 - lo),
                         $urandom_range(2, 9));
            run_rows(220, 1'b1);
        end
    endtask

    task automatic test_output_hold_off();
        int unsigned i;
        program_regs(0, -20, 20, 4);
        // receiver holds off while rows keep coming, so the input backs up;
        // single-beat rows up front make sure results pile up behind the output
        hold_request = 300;
        for (i = 0; i < 4; i++)
            send_beat(rand_beat(1'b1));
        run_rows(30, 1'b0);
        drain_results();
        run_rows(60, 1'b1);
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        weight      <= '0;
        act_col0    <= '0;
        act_col1    <= '0;
        bias        <= '0;
        scale_mult  <= '0;
        scale_shift <= '0;
        last_in_row <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_OUT_OFFSET;
        cfg_data    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_crossed_clamp();
        test_random_configs();
        test_output_hold_off();

        drain_results();
        $display("Sent %0d beats, checked %0d rows (%0d closing a channel pass), %0d reg writes.",
                 beats_sent, rows_checked, last_ch_rows, reg_writes);
        $display("Input held off on %0d cycles, output stalled with data on %0d cycles.",
                 in_stall_cycles, out_hold_cycles);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
